[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/sfp_pkg.sv]
`timescale 1ns / 1ps

package sfp_pkg;

  localparam int          TIMEOUT_W     = 16;
  localparam logic [15:0] TIMEOUT_RESET = 16'd100;
  localparam logic [7:0]  SYNC_BYTE     = 8'h55;
  localparam logic [15:0] CHECK_MULT    = 16'd211;

  // Parser phase
  typedef enum logic [2:0] {
    PH_SYNC = 3'd0,
    PH_ZERO = 3'd1,
    PH_LEN  = 3'd2,
    PH_TYPE = 3'd3,
    PH_BODY = 3'd4
  } sfp_phase_t;

  // Result event codes
  typedef enum logic [1:0] {
    EV_HEADER   = 2'd0,
    EV_PAYLOAD  = 2'd1,
    EV_ACCEPT   = 2'd2,
    EV_MISMATCH = 2'd3
  } sfp_event_t;

  // Item kind codes
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Strobes from the parser pipeline to the idle timer
  typedef struct packed {
    logic tick;
    logic byte_seen;
  } sfp_idle_ctrl_t;

  // One checksum step: add byte*211, then fold the high byte into the low.
  function automatic logic [15:0] check_update(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] sum;
    sum = c + (16'(d) * CHECK_MULT);
    return sum ^ {8'h00, sum[15:8]};
  endfunction

endpackage

[rtl/sfp_idle_timer.sv]
`timescale 1ns / 1ps

module sfp_idle_timer #(
  parameter int IDLE_COUNT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  sfp_pkg::sfp_idle_ctrl_t ctrl,
  input  logic [sfp_pkg::TIMEOUT_W-1:0] timeout,
  output logic                   timed_out
);
  import sfp_pkg::*;

  localparam int CmpW = (IDLE_COUNT_BITS > TIMEOUT_W) ? IDLE_COUNT_BITS : TIMEOUT_W;

  logic [IDLE_COUNT_BITS-1:0] idle_ticks;

  // Saturating tick count, cleared by every byte
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_ticks <= '0;
    end else if (ctrl.byte_seen) begin
      idle_ticks <= '0;
    end else if (ctrl.tick && (idle_ticks != '1)) begin
      idle_ticks <= idle_ticks + 1'b1;
    end
  end

  // Gap too long: compare at common width
  assign timed_out = CmpW'(idle_ticks) > CmpW'(timeout);

endmodule

[rtl/serial_frame_parser_checksum_unit.sv]
// Serial frame parser with running checksum. Each input beat is either one
// received UART byte (kind 0) or one timer tick (kind 1). Frames are sync byte
// 0x55, a zero byte, length, type, length payload bytes, then a checksum byte
// that must match the low byte of the running checksum. Every byte yields one
// output beat; ticks yield none and only advance a saturating idle counter.
// A byte arriving after more than timeout_ticks idle ticks restarts sync
// search first and is flagged with resynced. One beat per clock is accepted
// while the output is not stalled: a beat passes the input register, then the
// result register. Parser state updates straight from the input register,
// which sets that rate. The user must write the timeout register through the
// cfg channel only while the block is idle; the block does not enforce this.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module serial_frame_parser_checksum_unit #(
  parameter int IDLE_COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [7:0]  rx_byte,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  event_res,
  output logic [7:0]  payload_byte,
  output logic [7:0]  payload_index,
  output logic [7:0]  frame_length,
  output logic [7:0]  frame_type,
  output logic        resynced,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [sfp_pkg::TIMEOUT_W-1:0] cfg_data
);
  import sfp_pkg::*;

  logic [TIMEOUT_W-1:0] timeout_ticks;

  logic       s1_valid;
  logic       s1_kind;
  logic [7:0] s1_byte;
  logic       s1_fire;
  logic       out_free;
  logic       byte_fire;

  sfp_phase_t  phase, phase_eff, phase_next;
  logic [15:0] running_check, running_check_next;
  logic [7:0]  payload_count, payload_count_next;
  logic [7:0]  length_field, length_field_next;
  logic [7:0]  type_field, type_field_next;

  sfp_event_t ev;
  logic [7:0] pb, pi;
  logic       timed_out;
  sfp_idle_ctrl_t idle_ctrl;

  // Configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout_ticks <= cfg_data;
    end
  end

  // Handshake: ticks never need the output register
  assign out_free  = !out_valid || !out_stall;
  assign s1_fire   = s1_valid && ((s1_kind == KIND_TICK) || out_free);
  assign byte_fire = s1_fire && (s1_kind == KIND_BYTE);
  assign in_stall  = s1_valid && !s1_fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_kind <= kind;
      s1_byte <= rx_byte;
    end
  end

  // Idle tick counter
  assign idle_ctrl.tick      = s1_fire && (s1_kind == KIND_TICK);
  assign idle_ctrl.byte_seen = byte_fire;

  sfp_idle_timer #(
    .IDLE_COUNT_BITS(IDLE_COUNT_BITS)
  ) u_idle_timer (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (idle_ctrl),
    .timeout  (timeout_ticks),
    .timed_out(timed_out)
  );

  assign phase_eff = timed_out ? PH_SYNC : phase;

  // Next phase
  always_comb begin
    phase_next = PH_SYNC;
    unique case (phase_eff)
      PH_ZERO: phase_next = (s1_byte == 8'h00) ? PH_LEN : PH_SYNC;
      PH_LEN:  phase_next = PH_TYPE;
      PH_TYPE: phase_next = PH_BODY;
      PH_BODY: phase_next = (payload_count != length_field) ? PH_BODY : PH_SYNC;
      default: phase_next = (s1_byte == SYNC_BYTE) ? PH_ZERO : PH_SYNC;
    endcase
  end

  // Per-byte outputs and datapath updates
  always_comb begin
    logic [15:0] check_base;
    ev                 = EV_HEADER;
    pb                 = 8'h00;
    pi                 = 8'h00;
    payload_count_next = payload_count;
    length_field_next  = length_field;
    type_field_next    = type_field;
    check_base         = running_check;
    unique case (phase_eff)
      PH_ZERO: begin
      end
      PH_LEN: begin
        length_field_next  = s1_byte;
        payload_count_next = 8'h00;
      end
      PH_TYPE: begin
        type_field_next = s1_byte;
      end
      PH_BODY: begin
        if (payload_count != length_field) begin
          ev                 = EV_PAYLOAD;
          pb                 = s1_byte;
          pi                 = payload_count;
          payload_count_next = payload_count + 8'd1;
        end else begin
          ev = (s1_byte == running_check[7:0]) ? EV_ACCEPT : EV_MISMATCH;
        end
      end
      default: begin
        check_base = 16'h0000;
      end
    endcase
    running_check_next = check_update(check_base, s1_byte);
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SYNC;
      running_check <= '0;
      payload_count <= '0;
      length_field  <= '0;
      type_field    <= '0;
    end else if (byte_fire) begin
      phase         <= phase_next;
      running_check <= running_check_next;
      payload_count <= payload_count_next;
      length_field  <= length_field_next;
      type_field    <= type_field_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (byte_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_fire) begin
      event_res     <= ev;
      payload_byte  <= pb;
      payload_index <= pi;
      frame_length  <= length_field_next;
      frame_type    <= type_field_next;
      resynced      <= timed_out;
    end
  end

  // Checks
  `ASSERT_IMPL(a_count_in_frame, clk, rst, phase == PH_BODY, payload_count <= length_field)
  `ASSERT_IMPL(a_index_below_len, clk, rst, out_valid && (event_res == EV_PAYLOAD), payload_index < frame_length)
  `ASSERT_NEXT(a_tick_no_result, clk, rst, idle_ctrl.tick && !out_valid, !out_valid)
  `ASSERT_IMPL(a_stall_needs_item, clk, rst, in_stall, s1_valid && out_valid)

endmodule
